// ----- rtl/tat_pkg.sv -----
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types and constants of the tick alarm table: field widths, the
// controller state encoding and the command/status bundles.
// ----------------------------------------------------------------------------
package tat_pkg;

    localparam int unsigned TAT_ALARM_SLOTS = 16;

    localparam int unsigned RATE_W   = 16;
    localparam int unsigned THREAD_W = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned MS_W     = 64;
    localparam int unsigned END_W    = MS_W + 1;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd1000;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SLEEP = 1'b1;

    // radix-16 divider: four quotient bits per cycle
    localparam int unsigned DIV_BITS  = 4;
    localparam int unsigned DIV_STEPS = MS_W / DIV_BITS;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SLEEP,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic mul;
        logic div;
        logic sleep_store;
        logic scan_step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic op_sleep;
        logic div_done;
        logic scan_hit;
        logic scan_end;
        logic pend_valid;
    } t_status;

endpackage

// ----- rtl/tat_if.sv -----
// ----------------------------------------------------------------------------
// tat_if
// Valid/ready channels of the tick alarm table: request and result.
// ----------------------------------------------------------------------------
interface tat_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [tat_pkg::THREAD_W-1:0] thread_id;
    logic [tat_pkg::LEN_W-1:0]    sleep_ms;

    modport source (output valid, output operation, output thread_id,
                    output sleep_ms, input ready);
    modport sink   (input valid, input operation, input thread_id,
                    input sleep_ms, output ready);
endinterface

interface tat_out_if;
    logic                         valid;
    logic                         ready;
    logic                         wake_valid;
    logic [tat_pkg::THREAD_W-1:0] woken_thread;
    logic                         sleep_accepted;
    logic                         table_full;
    logic [tat_pkg::MS_W-1:0]     now_ms;
    logic                         last;

    modport source (output valid, output wake_valid, output woken_thread,
                    output sleep_accepted, output table_full, output now_ms,
                    output last, input ready);
    modport sink   (input valid, input wake_valid, input woken_thread,
                    input sleep_accepted, input table_full, input now_ms,
                    input last, output ready);
endinterface

// ----- rtl/tat_ctrl.sv -----
// ----------------------------------------------------------------------------
// tat_ctrl
// Sequencer of the tick alarm table: steps one request through multiply,
// divide, and then slot store or slot scan, throttled by the result register.
// ----------------------------------------------------------------------------
module tat_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tat_pkg::t_status i_status,
    output tat_pkg::t_cmd    o_cmd
);
    import tat_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   scan_blocked;

    // a hit with a result already pending needs the result register
    assign scan_blocked = i_status.scan_hit && i_status.pend_valid && !i_status.out_free;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_status.in_valid) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) n_state = i_status.op_sleep ? S_SLEEP : S_SCAN;
            end
            S_SLEEP: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_SCAN: begin
                if (!scan_blocked && i_status.scan_end) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd             = '0;
        o_cmd.in_ready    = (r_state == S_IDLE);
        o_cmd.mul         = (r_state == S_MUL);
        o_cmd.div         = (r_state == S_DIV);
        o_cmd.sleep_store = (r_state == S_SLEEP) && i_status.out_free;
        o_cmd.scan_step   = (r_state == S_SCAN) && !scan_blocked;
        o_cmd.flush       = (r_state == S_FLUSH) && i_status.out_free;
    end

endmodule

// ----- rtl/tat_dp.sv -----
// ----------------------------------------------------------------------------
// tat_dp
// Datapath of the tick alarm table: tick counter, rate register, millisecond
// multiply and radix-16 divider, alarm slot store and the result register.
// ----------------------------------------------------------------------------
module tat_dp #(
    parameter int unsigned ALARM_SLOTS = tat_pkg::TAT_ALARM_SLOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tat_pkg::RATE_W-1:0] i_cfg_wdata,
    input  tat_pkg::t_cmd              i_cmd,
    output tat_pkg::t_status           o_status,
    tat_in_if.sink                     i_in,
    tat_out_if.source                  o_out
);
    import tat_pkg::*;

    localparam int unsigned IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

    // control registers
    logic [RATE_W-1:0]    r_rate;
    logic [MS_W-1:0]      r_count;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_pend_valid;
    logic                 r_out_valid;
    logic [ALARM_SLOTS-1:0] r_slot_used;

    // payload registers
    logic                 r_op;
    logic [THREAD_W-1:0]  r_thread;
    logic [LEN_W-1:0]     r_len;
    logic [MS_W-1:0]      r_dvd;
    logic [RATE_W-1:0]    r_rem;
    logic [MS_W-1:0]      r_now;
    logic [THREAD_W-1:0]  r_pend_thread;
    logic [THREAD_W-1:0]  r_slot_thread [ALARM_SLOTS];
    logic [END_W-1:0]     r_slot_end    [ALARM_SLOTS];

    logic                 r_out_wake;
    logic [THREAD_W-1:0]  r_out_thread;
    logic                 r_out_acc;
    logic                 r_out_full;
    logic [MS_W-1:0]      r_out_now;
    logic                 r_out_last;

    logic                 in_xfer;
    logic                 out_xfer;
    logic [RATE_W-1:0]    divisor;
    logic [MS_W-1:0]      prod;
    logic [RATE_W-1:0]    n_rem;
    logic [DIV_BITS-1:0]  n_qbits;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic                 scan_hit;
    logic [END_W-1:0]     new_end;
    logic                 push_scan;

    assign in_xfer  = i_in.valid && i_cmd.in_ready;
    assign out_xfer = r_out_valid && o_out.ready;
    assign i_in.ready = i_cmd.in_ready;

    // zero rate divides as one
    assign divisor = (r_rate == '0) ? RATE_W'(1) : r_rate;

    // count * 1000 as 1024 - 32 + 8, modulo 2^64
    assign prod = (r_count << 10) - (r_count << 5) + (r_count << 3);

    // four restoring division steps per cycle
    always_comb begin
        logic [RATE_W:0] trial;
        logic [RATE_W-1:0] rem;
        rem     = r_rem;
        n_qbits = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {rem, r_dvd[MS_W-1-k]};
            if (trial >= {1'b0, divisor}) begin
                trial = trial - {1'b0, divisor};
                n_qbits[DIV_BITS-1-k] = 1'b1;
            end
            rem = trial[RATE_W-1:0];
        end
        n_rem = rem;
    end

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = ALARM_SLOTS - 1; s >= 0; s--) begin
            if (!r_slot_used[s]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(s);
            end
        end
    end

    assign new_end   = {1'b0, r_now} + {{(END_W-LEN_W){1'b0}}, r_len};
    assign scan_hit  = r_slot_used[r_idx] && ({1'b0, r_now} >= r_slot_end[r_idx]);
    assign push_scan = i_cmd.scan_step && scan_hit && r_pend_valid;

    // status to the sequencer
    always_comb begin
        o_status            = '0;
        o_status.in_valid   = i_in.valid;
        o_status.out_free   = !r_out_valid || o_out.ready;
        o_status.op_sleep   = (r_op == OP_SLEEP);
        o_status.div_done   = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_status.scan_hit   = scan_hit;
        o_status.scan_end   = (r_idx == IDX_W'(ALARM_SLOTS - 1));
        o_status.pend_valid = r_pend_valid;
    end

    // rate and tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= RATE_RESET;
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_rate  <= i_cfg_wdata;
            r_count <= '0;
        end else if (in_xfer && (i_in.operation == OP_TICK)) begin
            r_count <= r_count + MS_W'(1);
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op     <= i_in.operation;
            r_thread <= i_in.thread_id;
            r_len    <= i_in.sleep_ms;
        end
    end

    // multiply then divide; the dividend register fills with the quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.mul) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_dvd <= prod;
            r_rem <= '0;
        end else if (i_cmd.div) begin
            r_dvd <= {r_dvd[MS_W-DIV_BITS-1:0], n_qbits};
            r_rem <= n_rem;
            if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_now <= {r_dvd[MS_W-DIV_BITS-1:0], n_qbits};
            end
        end
    end

    // slot scan index and pending wake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.mul) begin
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (scan_hit) r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && scan_hit) begin
            r_pend_thread <= r_slot_thread[r_idx];
        end
    end

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_used <= '0;
        end else if (i_cmd.sleep_store && free_found) begin
            r_slot_used[free_idx] <= 1'b1;
        end else if (i_cmd.scan_step && scan_hit) begin
            r_slot_used[r_idx] <= 1'b0;
        end
    end

    // slot payload store
    always_ff @(posedge i_clk) begin
        if (i_cmd.sleep_store && free_found) begin
            r_slot_thread[free_idx] <= r_thread;
            r_slot_end[free_idx]    <= new_end;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.sleep_store || push_scan || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sleep_store) begin
            r_out_wake   <= 1'b0;
            r_out_thread <= '0;
            r_out_acc    <= free_found;
            r_out_full   <= !free_found;
            r_out_now    <= r_now;
            r_out_last   <= 1'b1;
        end else if (push_scan || i_cmd.flush) begin
            r_out_wake   <= r_pend_valid;
            r_out_thread <= r_pend_valid ? r_pend_thread : '0;
            r_out_acc    <= 1'b0;
            r_out_full   <= 1'b0;
            r_out_now    <= r_now;
            r_out_last   <= i_cmd.flush;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.wake_valid     = r_out_wake;
    assign o_out.woken_thread   = r_out_thread;
    assign o_out.sleep_accepted = r_out_acc;
    assign o_out.table_full     = r_out_full;
    assign o_out.now_ms         = r_out_now;
    assign o_out.last           = r_out_last;

endmodule

// ----- rtl/tick_alarm_table_core.sv -----
// ----------------------------------------------------------------------------
// tick_alarm_table_core
// Tick counter with a table of alarm slots that wakes sleeping threads.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every request first converts the tick
// count to milliseconds: the request is taken, the count is multiplied by
// 1000 and then divided by the tick rate (four quotient bits a cycle). A
// sleep request then stores its alarm and posts one result. A tick then
// walks the ALARM_SLOTS slots one per cycle, unless a wake must wait for a
// busy result register, and posts a final result. Results leave through a
// single output register. Writing the tick rate clears the tick count; write
// it only while no request is in flight.
module tick_alarm_table_core #(
    parameter int unsigned ALARM_SLOTS = tat_pkg::TAT_ALARM_SLOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tat_pkg::RATE_W-1:0] i_cfg_wdata,
    tat_in_if.sink                     i_in,
    tat_out_if.source                  o_out
);
    import tat_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    tat_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath
    tat_dp #(
        .ALARM_SLOTS (ALARM_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule
